>>> sv/horizontal_timing_char_fit_macros.svh
// Assertion macros for the horizontal timing fit block.
// Each macro expects clk and rst_n in scope.
`ifndef HORIZONTAL_TIMING_CHAR_FIT_MACROS_SVH
`define HORIZONTAL_TIMING_CHAR_FIT_MACROS_SVH

// Same-cycle implication.
`define HTCF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HTCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/htcf_pkg.sv
package htcf_pkg;

    // Field widths
    localparam int FREQ_W  = 18;
    localparam int WIDTH_W = 12;
    localparam int REG_W   = 15;
    localparam int END_W   = 12;
    localparam int PIX_W   = 14;

    // Line period in ps fits 40 bits (one second at most)
    localparam int LINE_W    = 40;
    localparam int MUL_SPLIT = 20;
    localparam int TGT_W     = 25;

    localparam logic [LINE_W-1:0] PS_PER_SECOND = 40'd1_000_000_000_000;
    localparam logic [TGT_W-1:0]  PS_PER_NS     = 25'd1000;
    localparam logic [TGT_W-1:0]  SLACK_PS      = 25'd200000;

    // Configuration register indexes
    localparam logic [1:0] CFG_FRONT_PORCH = 2'd0;
    localparam logic [1:0] CFG_SYNC_PULSE  = 2'd1;
    localparam logic [1:0] CFG_BACK_PORCH  = 2'd2;

    // Blanking count selects
    localparam logic [1:0] IDX_FP = 2'd0;
    localparam logic [1:0] IDX_SP = 2'd1;
    localparam logic [1:0] IDX_BP = 2'd2;

    typedef enum logic [1:0] {
        DSEL_LINE,
        DSEL_CELL
    } htcf_div_sel_t;

    typedef struct packed {
        logic          load;
        logic          div_start;
        htcf_div_sel_t div_sel;
        logic          line_take;
        logic          cell_take;
        logic          mul_lo;
        logic          mul_hi;
        logic          cmp;
        logic [1:0]    idx;
        logic          apply;
        logic          finish;
    } htcf_cmd_t;

    typedef struct packed {
        logic div_done;
        logic any_grow;
        logic last_pass;
    } htcf_stat_t;

endpackage

>>> sv/htcf_div.sv
module htcf_div
    import htcf_pkg::*;
#(
    parameter int DVS_W = 18
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [LINE_W-1:0] dividend,
    input  logic [DVS_W-1:0]  divisor,
    output logic              done,
    output logic [LINE_W-1:0] quotient
);

    localparam int CNT_W = $clog2(LINE_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [LINE_W-1:0] quo_reg;

    logic [DVS_W:0]   rem_shift;
    logic             take;
    logic [DVS_W:0]   rem_diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[LINE_W-1]};
        take      = (rem_shift >= {1'b0, dvs_reg});
        rem_diff  = rem_shift - {1'b0, dvs_reg};
    end

    // Sequence the bit steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(LINE_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
            quo_reg <= {quo_reg[LINE_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> sv/htcf_datapath.sv
module htcf_datapath
    import htcf_pkg::*;
#(
    parameter int CELL_WIDTH = 8,
    parameter int MAX_PASSES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  htcf_cmd_t          cmd,
    output htcf_stat_t         stat,
    input  logic [FREQ_W-1:0]  line_freq_hz,
    input  logic [WIDTH_W-1:0] active_width,
    input  logic [REG_W-1:0]   front_porch_ns,
    input  logic [REG_W-1:0]   sync_pulse_ns,
    input  logic [REG_W-1:0]   back_porch_ns,
    output logic               done,
    output logic [END_W-1:0]   active_end,
    output logic [PIX_W-1:0]   sync_start,
    output logic [PIX_W-1:0]   sync_end,
    output logic [PIX_W-1:0]   line_total,
    output logic               limit_hit
);

    localparam int CNT_W  = $clog2(MAX_PASSES + 2);
    localparam int PASS_W = $clog2(MAX_PASSES);
    localparam int TOT_W  = ((CNT_W > WIDTH_W) ? CNT_W : WIDTH_W) + 2;
    localparam int DVS_W  = (TOT_W > FREQ_W) ? TOT_W : FREQ_W;
    localparam int PROD_W = CNT_W + LINE_W;
    localparam int MP_W   = CNT_W + MUL_SPLIT;
    localparam int CMP_W  = PROD_W + 2;
    localparam int CW_W   = $clog2(CELL_WIDTH + 1);
    localparam int PX_W   = TOT_W + CW_W;
    localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(MAX_PASSES - 1);
    // Active cells by reciprocal multiply; five guard bits keep it exact
    // over the whole width range for cell widths up to 16
    localparam int ACT_SH  = WIDTH_W + 5;
    localparam int ACT_RCP = ((1 << ACT_SH) + CELL_WIDTH - 1) / CELL_WIDTH;
    localparam int ACT_PW  = WIDTH_W + ACT_SH + 1;

    logic [FREQ_W-1:0]  freq_reg;
    logic [WIDTH_W-1:0] act_reg;
    logic [LINE_W-1:0]  line_reg;
    logic [LINE_W-1:0]  cell_reg;
    logic [CNT_W-1:0]   fp_reg;
    logic [CNT_W-1:0]   sp_reg;
    logic [CNT_W-1:0]   bp_reg;
    logic [PASS_W-1:0]  pass_reg;
    logic               limit_reg;
    logic [2:0]         grow_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  now_reg;
    logic [TGT_W-1:0]   tgt_reg;
    logic               done_reg;
    logic [END_W-1:0]   active_end_reg;
    logic [PIX_W-1:0]   sync_start_reg;
    logic [PIX_W-1:0]   sync_end_reg;
    logic [PIX_W-1:0]   line_total_reg;

    logic [ACT_PW-1:0]  act_prod;
    logic [TOT_W-1:0]   total;
    logic [LINE_W-1:0]  div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic               div_done;
    logic [LINE_W-1:0]  div_q;
    logic [CNT_W-1:0]   cnt_sel;
    logic [REG_W-1:0]   tgt_ns_sel;
    logic [TGT_W-1:0]   tgt_ps;
    logic [MUL_SPLIT-1:0] mul_b;
    logic [MP_W-1:0]    mul_p;
    logic [PROD_W-1:0]  hi_add;
    logic               low_short;
    logic               near;
    logic               grow;
    logic [TOT_W-1:0]   sum_fp;
    logic [TOT_W-1:0]   sum_sp;
    logic [PX_W-1:0]    act_px;
    logic [PX_W-1:0]    fp_px;
    logic [PX_W-1:0]    sp_px;
    logic [PX_W-1:0]    tot_px;

    // Width times the cell reciprocal
    assign act_prod = ACT_PW'(active_width) * ACT_PW'(ACT_RCP);

    // Total cells on the line
    assign total = TOT_W'(act_reg) + TOT_W'(fp_reg) + TOT_W'(sp_reg) + TOT_W'(bp_reg);

    // Pick divider operands
    always_comb
    begin
        case (cmd.div_sel)
            DSEL_LINE:
            begin
                div_dividend = PS_PER_SECOND;
                div_divisor  = DVS_W'(freq_reg);
            end
            DSEL_CELL:
            begin
                div_dividend = line_reg;
                div_divisor  = DVS_W'(total);
            end
            default:
            begin
                div_dividend = line_reg;
                div_divisor  = DVS_W'(total);
            end
        endcase
    end

    htcf_div #(
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Pick the count and target under test
    always_comb
    begin
        case (cmd.idx)
            IDX_FP:
            begin
                cnt_sel    = fp_reg;
                tgt_ns_sel = front_porch_ns;
            end
            IDX_SP:
            begin
                cnt_sel    = sp_reg;
                tgt_ns_sel = sync_pulse_ns;
            end
            IDX_BP:
            begin
                cnt_sel    = bp_reg;
                tgt_ns_sel = back_porch_ns;
            end
            default:
            begin
                cnt_sel    = bp_reg;
                tgt_ns_sel = back_porch_ns;
            end
        endcase
    end

    // Count times cell time, in two halves of the cell time
    always_comb
    begin
        mul_b  = cmd.mul_hi ? MUL_SPLIT'(cell_reg[LINE_W-1:MUL_SPLIT])
                            : cell_reg[MUL_SPLIT-1:0];
        mul_p  = MP_W'(cnt_sel) * MP_W'(mul_b);
        hi_add = PROD_W'(mul_p) << MUL_SPLIT;
        tgt_ps = TGT_W'(tgt_ns_sel) * PS_PER_NS;
    end

    // Grow when far short, or when one more cell lands nearer the target
    always_comb
    begin
        low_short = (CMP_W'(now_reg) + CMP_W'(SLACK_PS)) < CMP_W'(tgt_reg);
        near      = (cell_reg != '0) &&
                    (((CMP_W'(now_reg) << 1) + CMP_W'(cell_reg)) < (CMP_W'(tgt_reg) << 1));
        grow      = low_short || near;
    end

    // Pixel positions of the finished layout
    always_comb
    begin
        sum_fp = TOT_W'(act_reg) + TOT_W'(fp_reg);
        sum_sp = sum_fp + TOT_W'(sp_reg);
        act_px = PX_W'(act_reg) * PX_W'(CELL_WIDTH);
        fp_px  = PX_W'(sum_fp) * PX_W'(CELL_WIDTH);
        sp_px  = PX_W'(sum_sp) * PX_W'(CELL_WIDTH);
        tot_px = PX_W'(total) * PX_W'(CELL_WIDTH);
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            freq_reg  <= (line_freq_hz == '0) ? FREQ_W'(1) : line_freq_hz;
            act_reg   <= act_prod[ACT_SH +: WIDTH_W];
            fp_reg    <= CNT_W'(1);
            sp_reg    <= CNT_W'(1);
            bp_reg    <= CNT_W'(1);
            pass_reg  <= '0;
            limit_reg <= 1'b0;
        end
        if (cmd.line_take)
        begin
            line_reg <= div_q;
        end
        if (cmd.cell_take)
        begin
            cell_reg <= div_q;
        end
        if (cmd.mul_lo)
        begin
            prod_reg <= PROD_W'(mul_p);
            tgt_reg  <= tgt_ps;
        end
        if (cmd.mul_hi)
        begin
            now_reg <= prod_reg + hi_add;
        end
        if (cmd.cmp)
        begin
            case (cmd.idx)
                IDX_FP:  grow_reg[0] <= grow;
                IDX_SP:  grow_reg[1] <= grow;
                IDX_BP:  grow_reg[2] <= grow;
                default: grow_reg[2] <= grow;
            endcase
        end
        // Advance counts and the pass number; flag a pass cap that still moved
        if (cmd.apply)
        begin
            fp_reg   <= fp_reg + CNT_W'(grow_reg[0]);
            sp_reg   <= sp_reg + CNT_W'(grow_reg[1]);
            bp_reg   <= bp_reg + CNT_W'(grow_reg[2]);
            pass_reg <= pass_reg + 1'b1;
            if ((grow_reg != '0) && (pass_reg == PASS_LAST))
            begin
                limit_reg <= 1'b1;
            end
        end
        if (cmd.finish)
        begin
            active_end_reg <= act_px[END_W-1:0];
            sync_start_reg <= fp_px[PIX_W-1:0];
            sync_end_reg   <= sp_px[PIX_W-1:0];
            line_total_reg <= tot_px[PIX_W-1:0];
        end
    end

    assign stat.div_done  = div_done;
    assign stat.any_grow  = (grow_reg != '0);
    assign stat.last_pass = (pass_reg == PASS_LAST);

    assign done       = done_reg;
    assign active_end = active_end_reg;
    assign sync_start = sync_start_reg;
    assign sync_end   = sync_end_reg;
    assign line_total = line_total_reg;
    assign limit_hit  = limit_reg;

endmodule

>>> sv/htcf_ctrl.sv
module htcf_ctrl
    import htcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  htcf_stat_t stat,
    output htcf_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LINE,
        S_LINE_W,
        S_CELL,
        S_CELL_W,
        S_MLO,
        S_MHI,
        S_CMP,
        S_APPLY,
        S_FIN
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;

    // Hold state and the count index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= IDX_FP;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Decode commands and the next state
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cmd         = '0;
        cmd.div_sel = DSEL_LINE;
        cmd.idx     = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LINE;
                end
            end
            S_LINE:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_LINE;
                state_next    = S_LINE_W;
            end
            S_LINE_W:
            begin
                if (stat.div_done)
                begin
                    cmd.line_take = 1'b1;
                    state_next    = S_CELL;
                end
            end
            S_CELL:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_CELL;
                state_next    = S_CELL_W;
            end
            S_CELL_W:
            begin
                if (stat.div_done)
                begin
                    cmd.cell_take = 1'b1;
                    idx_next      = IDX_FP;
                    state_next    = S_MLO;
                end
            end
            S_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp = 1'b1;
                if (idx_reg == IDX_BP)
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_MLO;
                end
            end
            S_APPLY:
            begin
                cmd.apply = 1'b1;
                if (!stat.any_grow || stat.last_pass)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_CELL;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> sv/horizontal_timing_char_fit.sv
// Horizontal timing fit in character cells.
// Pulse start with line_freq_hz and active_width while busy is low; the beat is
// taken at that edge and busy rises. The block lays out the line in cells of
// CELL_WIDTH pixels, grows the front porch, sync and back porch counts pass by
// pass toward the porch targets, and then shows one result beat: done is high
// for exactly one cycle with active_end, sync_start, sync_end, line_total and
// limit_hit valid. The receiver cannot stall; the pixel results hold until the
// next item finishes, limit_hit until the next item is taken, and a new start
// is taken in the cycle done is high.
// An item takes from 1 to MAX_PASSES passes.
// Active cells come from a reciprocal multiply as the item is taken. The line
// period and the cell time of each pass run through one shared restoring
// divider at one quotient bit per cycle, 40 bits; the three count checks of a
// pass share one multiplier: low half, high half, then compare.
// The block works on one item at a time.
// Target registers are written through cfg_we, cfg_index and cfg_data; the user
// must do so only while the block is idle, which the block does not enforce;
// indexes beyond the last register are ignored. Reset (rst_n low, asynchronous)
// returns to idle and restores the default targets of 2000, 4700 and 5700 ns.
module horizontal_timing_char_fit
    import htcf_pkg::*;
#(
    parameter int CELL_WIDTH = 8,
    parameter int MAX_PASSES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FREQ_W-1:0]  line_freq_hz,
    input  logic [WIDTH_W-1:0] active_width,
    output logic               done,
    output logic [END_W-1:0]   active_end,
    output logic [PIX_W-1:0]   sync_start,
    output logic [PIX_W-1:0]   sync_end,
    output logic [PIX_W-1:0]   line_total,
    output logic               limit_hit,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [REG_W-1:0]   cfg_data
);

`include "horizontal_timing_char_fit_macros.svh"

    logic [REG_W-1:0] front_porch_reg;
    logic [REG_W-1:0] sync_pulse_reg;
    logic [REG_W-1:0] back_porch_reg;

    htcf_cmd_t  cmd;
    htcf_stat_t stat;

    // Hold the porch targets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_porch_reg <= REG_W'(2000);
            sync_pulse_reg  <= REG_W'(4700);
            back_porch_reg  <= REG_W'(5700);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRONT_PORCH: front_porch_reg <= cfg_data;
                CFG_SYNC_PULSE:  sync_pulse_reg  <= cfg_data;
                CFG_BACK_PORCH:  back_porch_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    htcf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    htcf_datapath #(
        .CELL_WIDTH (CELL_WIDTH),
        .MAX_PASSES (MAX_PASSES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .line_freq_hz   (line_freq_hz),
        .active_width   (active_width),
        .front_porch_ns (front_porch_reg),
        .sync_pulse_ns  (sync_pulse_reg),
        .back_porch_ns  (back_porch_reg),
        .done           (done),
        .active_end     (active_end),
        .sync_start     (sync_start),
        .sync_end       (sync_end),
        .line_total     (line_total),
        .limit_hit      (limit_hit)
    );

    // A result beat follows the end of a busy stretch
    `HTCF_ASSERT_NOW(a_done_after_busy, done, !busy && $past(busy), "done without a finished item")
    // An accepted start makes the block busy
    `HTCF_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted start did not raise busy")
    // Each result beat is a lone pulse of done
    `HTCF_ASSERT_NEXT(a_done_pulse, done, !done, "done held for more than one cycle")
    // Divider start, apply and finish commands only issue while an item is at work
    `HTCF_ASSERT_NOW(a_cmd_busy, cmd.apply || cmd.finish || cmd.div_start, busy, "command while idle")

endmodule

>>> bench/tb.sv
module tb;
    import htcf_pkg::*;

    localparam int CELL_PIX   = 8;
    localparam int PASS_CAP   = 64;
    localparam longint ONE_SECOND_PS = 64'd1_000_000_000_000;
    localparam longint NS_PS         = 1000;
    localparam longint GROW_SLACK_PS = 200000;

    // No register sits at this index: writes there must be dropped
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [END_W-1:0] active_end;
        logic [PIX_W-1:0] sync_start;
        logic [PIX_W-1:0] sync_end;
        logic [PIX_W-1:0] line_total;
        logic             limit_hit;
    } line_timing_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [FREQ_W-1:0]  line_freq_hz = '0;
    logic [WIDTH_W-1:0] active_width = '0;
    logic               done;
    logic [END_W-1:0]   active_end;
    logic [PIX_W-1:0]   sync_start;
    logic [PIX_W-1:0]   sync_end;
    logic [PIX_W-1:0]   line_total;
    logic               limit_hit;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [REG_W-1:0]   cfg_data = '0;

    // Shadow copies of the porch targets, in ns
    logic [REG_W-1:0] tgt_front_ns = 15'd2000;
    logic [REG_W-1:0] tgt_sync_ns  = 15'd4700;
    logic [REG_W-1:0] tgt_back_ns  = 15'd5700;

    line_timing_t timing_due_q[$];
    int           mismatches = 0;
    int           sender_idle_pct = 0;

    horizontal_timing_char_fit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .line_freq_hz (line_freq_hz),
        .active_width (active_width),
        .done         (done),
        .active_end   (active_end),
        .sync_start   (sync_start),
        .sync_end     (sync_end),
        .line_total   (line_total),
        .limit_hit    (limit_hit),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run
    initial
    begin
        #250_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Decide whether a porch of n cells should take one more cell
    function automatic bit porch_grows(input longint n, input longint cell_ps,
                                       input logic [REG_W-1:0] tgt_ns);
        longint tgt_ps;
        longint cur_ps;
        longint next_ps;
        longint cur_gap;
        longint next_gap;
        tgt_ps  = longint'(tgt_ns) * NS_PS;
        cur_ps  = n * cell_ps;
        next_ps = (n + 1) * cell_ps;
        if (cur_ps < tgt_ps - GROW_SLACK_PS)
            return 1'b1;
        cur_gap  = (cur_ps > tgt_ps) ? cur_ps - tgt_ps : tgt_ps - cur_ps;
        next_gap = (next_ps > tgt_ps) ? next_ps - tgt_ps : tgt_ps - next_ps;
        return next_gap < cur_gap;
    endfunction

    // Lay out one line in cells and grow the porches pass by pass
    function automatic line_timing_t fit_line_timing(input logic [FREQ_W-1:0] freq,
                                                     input logic [WIDTH_W-1:0] width);
        line_timing_t res;
        longint       hz;
        longint       period_ps;
        longint       act;
        longint       fp;
        longint       sp;
        longint       bp;
        longint       cell_ps;
        bit           gf;
        bit           gs;
        bit           gb;
        bit           capped;
        hz = longint'(freq);
        if (hz == 0)
            hz = 1;
        period_ps = ONE_SECOND_PS / hz;
        act = longint'(width) / CELL_PIX;
        fp = 1;
        sp = 1;
        bp = 1;
        capped = 1'b0;
        for (int p = 0; p < PASS_CAP; p++)
        begin
            cell_ps = period_ps / (act + fp + sp + bp);
            gf = porch_grows(fp, cell_ps, tgt_front_ns);
            gs = porch_grows(sp, cell_ps, tgt_sync_ns);
            gb = porch_grows(bp, cell_ps, tgt_back_ns);
            fp += gf;
            sp += gs;
            bp += gb;
            if (!gf && !gs && !gb)
                break;
            if (p == PASS_CAP - 1)
                capped = 1'b1;
        end
        res.active_end = END_W'(act * CELL_PIX);
        res.sync_start = PIX_W'((act + fp) * CELL_PIX);
        res.sync_end   = PIX_W'((act + fp + sp) * CELL_PIX);
        res.line_total = PIX_W'((act + fp + sp + bp) * CELL_PIX);
        res.limit_hit  = capped;
        return res;
    endfunction

    // Check each result beat against the oldest pending layout
    always @(posedge clk)
    begin : check_results
        line_timing_t want;
        if (rst_n && done)
        begin
            if (timing_due_q.size() == 0)
                report_mismatch("result beat with nothing pending");
            else
            begin
                want = timing_due_q.pop_front();
                compare_field("active_end", 16'(active_end), 16'(want.active_end));
                compare_field("sync_start", 16'(sync_start), 16'(want.sync_start));
                compare_field("sync_end", 16'(sync_end), 16'(want.sync_end));
                compare_field("line_total", 16'(line_total), 16'(want.line_total));
                compare_field("limit_hit", 16'(limit_hit), 16'(want.limit_hit));
            end
        end
    end

    // Write one target register; call at a falling edge with the block idle
    task automatic cfg_write(input logic [1:0] idx, input logic [REG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_FRONT_PORCH: tgt_front_ns = val;
            CFG_SYNC_PULSE:  tgt_sync_ns  = val;
            CFG_BACK_PORCH:  tgt_back_ns  = val;
            default:         ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_targets(input logic [REG_W-1:0] fp_ns, input logic [REG_W-1:0] sp_ns,
                               input logic [REG_W-1:0] bp_ns);
        cfg_write(CFG_FRONT_PORCH, fp_ns);
        cfg_write(CFG_SYNC_PULSE, sp_ns);
        cfg_write(CFG_BACK_PORCH, bp_ns);
    endtask

    // Send one beat, then idle at random; start stays high when no gap follows
    task automatic send_beat(input logic [FREQ_W-1:0] freq, input logic [WIDTH_W-1:0] width);
        int gap;
        start        <= 1'b1;
        line_freq_hz <= freq;
        active_width <= width;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        timing_due_q.push_back(fit_line_timing(freq, width));
        @(negedge clk);
        gap = 0;
        if (sender_idle_pct > 0)
        begin
            while ($urandom_range(99) < sender_idle_pct)
                gap++;
            if ($urandom_range(49) == 0)
                gap += $urandom_range(1, 600);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drop start and hold until every pending result has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (timing_due_q.size() != 0 || busy)
            @(negedge clk);
    endtask

    function automatic logic [REG_W-1:0] pick_target();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 15'd20000;
            2:       return '1;
            3, 4:    return REG_W'($urandom_range(32767));
            default: return REG_W'($urandom_range(1000, 8000));
        endcase
    endfunction

    // Low frequencies settle in few passes; keep them the bulk of the traffic
    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return FREQ_W'($urandom_range(1000, 12000));
            5, 6:          return FREQ_W'($urandom_range(12000, 80000));
            7:             return FREQ_W'($urandom_range(80000, 200000));
            8:             return FREQ_W'($urandom_range(262143));
            default:
            begin
                case ($urandom_range(3))
                    0:       return '0;
                    1:       return 18'd1;
                    2:       return '1;
                    default: return FREQ_W'($urandom_range(999));
                endcase
            end
        endcase
    endfunction

    function automatic logic [WIDTH_W-1:0] pick_width();
        if ($urandom_range(7) == 0)
            return WIDTH_W'($urandom_range(15));
        return WIDTH_W'($urandom_range(4095));
    endfunction

    // Default targets: zero and extreme frequencies, cell edges of the width
    task automatic test_default_targets();
        sender_idle_pct = 0;
        send_beat(18'd0, 12'd640);
        send_beat(18'd1, 12'd0);
        send_beat(18'd1000, 12'd4095);
        send_beat(18'd15734, 12'd640);
        send_beat(18'd31469, 12'd640);
        send_beat(18'd200000, 12'd4095);
        send_beat('1, 12'd0);
        send_beat('1, 12'd4095);
        send_beat(18'd48000, 12'd7);
        send_beat(18'd64000, 12'd8);
        wait_drained();
    endtask

    // Target extremes, alternating bit patterns and the unused register index
    task automatic test_target_registers();
        set_targets('0, '0, '0);
        send_beat(18'd31469, 12'd1024);
        send_beat(18'd200000, 12'd0);
        wait_drained();
        set_targets('1, '1, '1);
        send_beat(18'd1000, 12'd4095);
        send_beat('1, 12'd4095);
        send_beat(18'd31469, 12'd0);
        wait_drained();
        set_targets(15'd20000, 15'd0, 15'd20000);
        send_beat(18'd60000, 12'd1920);
        wait_drained();
        cfg_write(CFG_UNUSED, '0);
        send_beat(18'd60000, 12'd1920);
        wait_drained();
        set_targets(15'h2AAA, 15'h5555, 15'h2AAA);
        send_beat(18'h2AAAA, 12'hAAA);
        send_beat(18'h15555, 12'h555);
        wait_drained();
    endtask

    // Random beats under three target settings at one sender idle rate
    task automatic test_random_traffic(input int idle_pct, input int n_items);
        sender_idle_pct = idle_pct;
        for (int s = 0; s < 3; s++)
        begin
            wait_drained();
            set_targets(pick_target(), pick_target(), pick_target());
            if ($urandom_range(3) == 0)
                cfg_write(CFG_UNUSED, REG_W'($urandom_range(32767)));
            for (int i = 0; i < n_items / 3; i++)
            begin
                if ($urandom_range(39) == 0)
                    wait_drained();
                send_beat(pick_freq(), pick_width());
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_default_targets();
        test_target_registers();
        test_random_traffic(0, 432);
        test_random_traffic(74, 432);
        test_random_traffic(17, 432);
        wait_drained();
        repeat (100) @(negedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
